### hdl/mdda_pkg.sv
package mdda_pkg;

    // built axis count and the axes carried by the stream fields
    localparam int MAX_AXES = 4;
    localparam int IO_AXES  = 4;

    // field widths
    localparam int KIND_W   = 2;
    localparam int STEPS_W  = 17;
    localparam int FLAGS_W  = 8;
    localparam int TICKS_W  = 16;
    localparam int ACC_W    = 17;
    localparam int POS_W    = 32;
    localparam int AXCNT_W  = 3;
    localparam int MASK_W   = 4;

    // stream payload widths, padded to whole bytes
    localparam int IN_BITS       = IO_AXES * STEPS_W + FLAGS_W;
    localparam int IN_TDATA_W    = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS      = MASK_W + 2 + FLAGS_W + IO_AXES * POS_W;
    localparam int OUT_TDATA_W   = ((OUT_BITS + 7) / 8) * 8;

    // result field offsets
    localparam int OUT_ACC_BIT   = MASK_W;
    localparam int OUT_RUN_BIT   = MASK_W + 1;
    localparam int OUT_FLAGS_LSB = MASK_W + 2;
    localparam int OUT_POS_LSB   = MASK_W + 2 + FLAGS_W;

    // apb
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;

    // register reset values
    localparam logic [AXCNT_W-1:0] AXIS_COUNT_RST    = AXCNT_W'(4);
    localparam logic [TICKS_W-1:0] SEGMENT_TICKS_RST = TICKS_W'(1000);

    // register index, taken from paddr[2]
    localparam logic REG_AXIS_COUNT    = 1'b0;
    localparam logic REG_SEGMENT_TICKS = 1'b1;

    typedef enum logic [KIND_W-1:0] {
        KIND_TICK   = 2'd0,
        KIND_LOAD   = 2'd1,
        KIND_CLEAR  = 2'd2,
        KIND_UNUSED = 2'd3
    } kind_t;

    // per-axis commands for one beat
    typedef struct packed {
        logic tick;
        logic load;
        logic clear;
    } axis_ctrl_t;

endpackage

### hdl/mdda_axis.sv
module mdda_axis (
    input  logic                              clk,
    input  logic                              rst_n,
    input  mdda_pkg::axis_ctrl_t              ctrl,
    input  logic [mdda_pkg::STEPS_W-1:0]      steps,
    input  logic [mdda_pkg::TICKS_W-1:0]      segment_ticks,
    output logic                              range_ok,
    output logic                              step,
    output logic [mdda_pkg::POS_W-1:0]        position
);
    import mdda_pkg::*;

    logic [ACC_W-1:0]   acc_reg, acc_next;
    logic [TICKS_W-1:0] rate_reg, rate_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic               dir_reg, dir_next;

    logic [STEPS_W-1:0] magnitude;
    logic [ACC_W-1:0]   limit;
    logic [ACC_W-1:0]   sum;

    // magnitude of the signed step count and range check against T
    assign magnitude = steps[STEPS_W-1] ? (~steps + STEPS_W'(1)) : steps;
    assign limit     = {{(ACC_W-TICKS_W){1'b0}}, segment_ticks};
    assign range_ok  = (ACC_W'(magnitude) <= limit);

    // accumulate, wrap at 17 bits
    assign sum  = acc_reg + {{(ACC_W-TICKS_W){1'b0}}, rate_reg};
    assign step = ctrl.tick && (sum >= limit);

    // next state
    always_comb
    begin
        acc_next  = acc_reg;
        rate_next = rate_reg;
        pos_next  = pos_reg;
        dir_next  = dir_reg;
        if (ctrl.tick)
        begin
            acc_next = step ? (sum - limit) : sum;
            if (step)
            begin
                pos_next = dir_reg ? (pos_reg + POS_W'(1)) : (pos_reg - POS_W'(1));
            end
        end
        if (ctrl.load)
        begin
            if (steps != '0)
            begin
                dir_next = ~steps[STEPS_W-1];
            end
            rate_next = magnitude[TICKS_W-1:0];
            acc_next  = {{(ACC_W-TICKS_W+1){1'b0}}, segment_ticks[TICKS_W-1:1]};
        end
        if (ctrl.clear)
        begin
            rate_next = '0;
        end
    end

    // axis state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg  <= '0;
            rate_reg <= '0;
            pos_reg  <= '0;
            dir_reg  <= 1'b1;
        end
        else
        begin
            acc_reg  <= acc_next;
            rate_reg <= rate_next;
            pos_reg  <= pos_next;
            dir_reg  <= dir_next;
        end
    end

    assign position = pos_reg;

endmodule

### hdl/multi_axis_dda_step_generator.sv
// an accepted beat is held in the input stage registers, then its result is registered in the result stage
// throughput: one item per cycle, held back only while the result beat is not taken
// each item is handled in one pass through the per-axis add, compare and subtract
// reset: asynchronous, active low; clears positions, accumulators, rates and the segment,
// sets all direction bits and loads axis_count 4 and segment_ticks 1000
module multi_axis_dda_step_generator (
    input  logic                                clk,
    input  logic                                rst_n,
    // input beats
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // steps_axis0, steps_axis1, steps_axis2, steps_axis3, segment_flags, zero pad
    input  logic [mdda_pkg::IN_TDATA_W-1:0]     s_tdata,
    // kind
    input  logic [mdda_pkg::KIND_W-1:0]         s_tuser,
    // result beats
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // step_mask, load_accepted, segment_running, current_flags,
    // position_axis0, position_axis1, position_axis2, position_axis3, zero pad
    output logic [mdda_pkg::OUT_TDATA_W-1:0]    m_tdata,
    // configuration
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [mdda_pkg::ADDR_W-1:0]         paddr,
    input  logic [mdda_pkg::DATA_W-1:0]         pwdata,
    output logic [mdda_pkg::DATA_W-1:0]         prdata,
    output logic                                pready
);
    import mdda_pkg::*;

    // configuration registers
    logic [AXCNT_W-1:0] axis_count_reg;
    logic [TICKS_W-1:0] seg_ticks_reg;

    // input stage
    logic                  in_valid_reg, in_valid_next;
    logic [KIND_W-1:0]     in_kind_reg;
    logic [IN_BITS-1:0]    in_data_reg;

    // segment state
    logic [TICKS_W-1:0] tick_reg, tick_next;
    logic               active_reg, active_next;
    logic [FLAGS_W-1:0] flags_reg, flags_next;

    // result stage
    logic               out_valid_reg, out_valid_next;
    logic [MASK_W-1:0]  mask_reg;
    logic               accepted_reg, accepted_next;
    logic               running_reg, running_next;

    logic               accept;
    logic               fire;
    logic               running_now;
    logic               all_ok;
    logic               do_tick, do_load, do_clear;
    kind_t              kind;

    logic [MAX_AXES-1:0] used;
    logic [MAX_AXES-1:0] range_ok;
    logic [MAX_AXES-1:0] step_bits;
    logic [POS_W-1:0]    positions [MAX_AXES];
    logic [MASK_W-1:0]   mask_next;

    // handshake: take a beat while the stage is empty or moving on
    assign fire     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || fire;
    assign accept   = s_tvalid && s_tready;

    assign in_valid_next  = accept ? 1'b1 : (fire ? 1'b0 : in_valid_reg);
    assign out_valid_next = fire ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);

    // apb register file
    assign pready = 1'b1;

    always_comb
    begin
        unique case (paddr[2])
            REG_AXIS_COUNT:    prdata = DATA_W'(axis_count_reg);
            REG_SEGMENT_TICKS: prdata = DATA_W'(seg_ticks_reg);
            default:           prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            axis_count_reg <= AXIS_COUNT_RST;
            seg_ticks_reg  <= SEGMENT_TICKS_RST;
        end
        else if (psel && penable && pwrite && pready)
        begin
            unique case (paddr[2])
                REG_AXIS_COUNT:    axis_count_reg <= pwdata[AXCNT_W-1:0];
                REG_SEGMENT_TICKS: seg_ticks_reg  <= pwdata[TICKS_W-1:0];
                default:           ;
            endcase
        end
    end

    // segment control for the beat in the input stage
    assign kind        = kind_t'(in_kind_reg);
    assign running_now = active_reg && (tick_reg < seg_ticks_reg);
    assign all_ok      = &(range_ok | ~used);

    always_comb
    begin
        tick_next     = tick_reg;
        active_next   = active_reg;
        flags_next    = flags_reg;
        accepted_next = 1'b0;
        do_tick       = 1'b0;
        do_load       = 1'b0;
        do_clear      = 1'b0;
        case (kind)
            KIND_TICK:
            begin
                if (running_now)
                begin
                    do_tick   = 1'b1;
                    tick_next = tick_reg + TICKS_W'(1);
                end
            end
            KIND_LOAD:
            begin
                if (all_ok)
                begin
                    do_load       = 1'b1;
                    tick_next     = '0;
                    active_next   = 1'b1;
                    flags_next    = in_data_reg[IO_AXES*STEPS_W +: FLAGS_W];
                    accepted_next = 1'b1;
                end
            end
            KIND_CLEAR:
            begin
                do_clear    = 1'b1;
                tick_next   = '0;
                active_next = 1'b0;
                flags_next  = '0;
            end
            default:
            begin
            end
        endcase
        running_next = active_next && (tick_next < seg_ticks_reg);
    end

    // axis units
    for (genvar g = 0; g < MAX_AXES; g++)
    begin : g_axis
        axis_ctrl_t         ctrl;
        logic [STEPS_W-1:0] axis_steps;

        assign used[g]    = (axis_count_reg > AXCNT_W'(g));
        assign ctrl.tick  = fire && do_tick && used[g];
        assign ctrl.load  = fire && do_load && used[g];
        assign ctrl.clear = fire && do_clear;

        if (g < IO_AXES)
        begin : g_io
            assign axis_steps = in_data_reg[g*STEPS_W +: STEPS_W];
        end
        else
        begin : g_zero
            assign axis_steps = '0;
        end

        mdda_axis u_axis (
            .clk           (clk),
            .rst_n         (rst_n),
            .ctrl          (ctrl),
            .steps         (axis_steps),
            .segment_ticks (seg_ticks_reg),
            .range_ok      (range_ok[g]),
            .step          (step_bits[g]),
            .position      (positions[g])
        );
    end

    assign mask_next = MASK_W'(step_bits);

    // input stage registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_kind_reg <= s_tuser;
            in_data_reg <= s_tdata[IN_BITS-1:0];
        end
    end

    // segment state and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_reg      <= '0;
            active_reg    <= 1'b0;
            flags_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (fire)
            begin
                tick_reg   <= tick_next;
                active_reg <= active_next;
                flags_reg  <= flags_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            mask_reg     <= mask_next;
            accepted_reg <= accepted_next;
            running_reg  <= running_next;
        end
    end

    // result beat; positions and flags only change when the next result is made
    always_comb
    begin
        m_tdata                               = '0;
        m_tdata[MASK_W-1:0]                   = mask_reg;
        m_tdata[OUT_ACC_BIT]                  = accepted_reg;
        m_tdata[OUT_RUN_BIT]                  = running_reg;
        m_tdata[OUT_FLAGS_LSB +: FLAGS_W]     = flags_reg;
        for (int i = 0; i < IO_AXES; i++)
        begin
            if (i < MAX_AXES)
            begin
                m_tdata[OUT_POS_LSB + i*POS_W +: POS_W] = positions[i];
            end
        end
    end

    assign m_tvalid = out_valid_reg;

endmodule

### hdl/mdda_checker.sv
module mdda_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                s_tready,
    input logic                                m_tvalid,
    input logic                                m_tready,
    input logic [mdda_pkg::OUT_TDATA_W-1:0]    m_tdata
);
    import mdda_pkg::*;

    // a stalled result beat stays valid
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result beat dropped while stalled");

    // a stalled result beat keeps its payload
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result payload changed while stalled");

    // input is only held off while a result beat is stalled
    a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input held off without a stalled result");

    // a load result never carries step pulses
    a_load_no_step: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[OUT_ACC_BIT] |-> (m_tdata[MASK_W-1:0] == '0))
        else $error("step pulses reported with an accepted load");

endmodule

bind multi_axis_dda_step_generator mdda_checker u_mdda_checker (.*);
